// ----- design/jsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants of the JSON string field extractor: character
// codes, status codes, register indexes and the command passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package jsfe_pkg;

	// character codes
	localparam logic [7:0] CH_COLON     = 8'h3a;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_NUL       = 8'h00;

	// status codes on the closing item
	localparam logic [2:0] ST_FOUND        = 3'd0;
	localparam logic [2:0] ST_NO_KEY       = 3'd1;
	localparam logic [2:0] ST_NO_COLON     = 3'd2;
	localparam logic [2:0] ST_NOT_STRING   = 3'd3;
	localparam logic [2:0] ST_UNTERMINATED = 3'd4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_TOP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_SIZE  = 3'd5;

	// key storage: 4 words of 8 characters, 31 characters addressable
	localparam int KEY_BITS  = 4 * CFG_DATA_W;
	localparam int KEY_CHARS = 31;
	localparam int KLEN_W    = 5;
	localparam int OSIZE_W   = 7;
	localparam logic [OSIZE_W-1:0] OSIZE_RESET = 7'd64;

	// command queue between front and back
	localparam int CNT_W       = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		CMD_STORE,
		CMD_EMIT,
		CMD_STATUS
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [7:0]       data;
		logic [CNT_W-1:0] cnt;
		logic [2:0]       code;
	} cmd_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

endpackage

`default_nettype wire

// ----- design/jsfe_in_if.sv -----
// ----------------------------------------------------------------------------
// jsfe_in_if
// Text channel: one character or terminator per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, output text_byte, output end_of_text, input ready);
	modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ----- design/jsfe_out_if.sv -----
// ----------------------------------------------------------------------------
// jsfe_out_if
// Result channel: value bytes followed by one closing status item.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic [2:0] status;
	logic       last;

	modport source(output valid, output value_byte, output status, output last,
		input ready);
	modport sink(input valid, input value_byte, input status, input last,
		output ready);
endinterface

`default_nettype wire

// ----- design/jsfe_front.sv -----
// ----------------------------------------------------------------------------
// jsfe_front
// Accepts text characters, runs the key search window and the colon / quote /
// value parser, and issues store, emit and status commands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfe_front import jsfe_pkg::*; #(
	parameter int PATTERN_MAX = 31,
	parameter int VALUE_MAX   = 63
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	jsfe_in_if.sink                    text_in,
	output logic                       cmd_push,
	output cmd_t                       cmd,
	input  wire logic                  cmd_full
);

	localparam int CW  = $clog2(VALUE_MAX + 1);
	localparam int PLW = $clog2(PATTERN_MAX + 1);

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_COLON,
		PH_QUOTE,
		PH_VALUE,
		PH_DONE
	} phase_t;

	logic [KEY_BITS-1:0] key_bits_q;
	logic [KLEN_W-1:0]   key_length_q;
	logic [OSIZE_W-1:0]  dest_size_q;

	logic [7:0]          exp_d [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] care_d;
	logic [7:0]          exp_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] care_q;
	logic [KLEN_W-1:0]   first_zero;
	logic [KLEN_W-1:0]   klen;
	logic [KLEN_W:0]     plen_full;
	logic [PLW-1:0]      plen;

	logic [7:0]          window_q [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hit;
	logic                win_match;
	logic                chk_q;

	phase_t              phase_q, phase_d, ph_eff;
	logic                esc_q, esc_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [OSIZE_W-1:0]  os_lim;
	logic [CW-1:0]       emit_cnt;

	logic                accept;
	logic                term;
	logic [7:0]          c;
	logic                shift;
	logic                clear;

	assign text_in.ready = !cmd_full;
	assign accept        = text_in.valid && text_in.ready;
	assign c             = text_in.text_byte;
	assign term          = text_in.end_of_text || (c == CH_NUL);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bits_q   <= '0;
			key_length_q <= '0;
			dest_size_q  <= OSIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_LOW:    key_bits_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				CFG_KEY_MID:    key_bits_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				CFG_KEY_HIGH:   key_bits_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				CFG_KEY_TOP:    key_bits_q[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				CFG_KEY_LENGTH: key_length_q <= cfg_data[KLEN_W-1:0];
				CFG_DEST_SIZE:  dest_size_q  <= cfg_data[OSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// quoted pattern, right-aligned to the window, with a care mask
	always_comb begin
		int k;
		first_zero = KLEN_W'(KEY_CHARS);
		for (int i = KEY_CHARS - 1; i >= 0; i--) begin
			if (key_bits_q[8*i +: 8] == CH_NUL) first_zero = KLEN_W'(i);
		end
		klen      = (key_length_q < first_zero) ? key_length_q : first_zero;
		plen_full = {1'b0, klen} + (KLEN_W + 1)'(2);
		plen      = (plen_full > (KLEN_W + 1)'(PATTERN_MAX)) ? PLW'(PATTERN_MAX)
			: PLW'(plen_full);
		for (int p = 0; p < PATTERN_MAX; p++) begin
			k = p - (PATTERN_MAX - int'(plen));
			care_d[p] = 1'b0;
			exp_d[p]  = CH_QUOTE;
			if (k >= 0) begin
				care_d[p] = 1'b1;
				if (k > 0 && k <= int'(klen)) exp_d[p] = key_bits_q[8*(k-1) +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		exp_q  <= exp_d;
		care_q <= care_d;
	end

	// window compare, valid once a character has been shifted in
	always_comb begin
		for (int p = 0; p < PATTERN_MAX; p++) begin
			hit[p] = !care_q[p] || (window_q[p] == exp_q[p]);
		end
	end
	assign win_match = chk_q && (&hit);

	// a matched window means the parser already waits for the colon
	assign ph_eff = (phase_q == PH_SEARCH && win_match) ? PH_COLON : phase_q;

	// emitted length: destination size - 1, capped at the stored count
	always_comb begin
		os_lim   = (dest_size_q == '0) ? '0 : dest_size_q - OSIZE_W'(1);
		emit_cnt = (os_lim < OSIZE_W'(cnt_q)) ? CW'(os_lim) : cnt_q;
	end

	// parser step and command selection
	always_comb begin
		cmd_push = 1'b0;
		cmd      = '{op: CMD_STATUS, data: '0, cnt: '0, code: ST_FOUND};
		phase_d  = phase_q;
		esc_d    = esc_q;
		cnt_d    = cnt_q;
		shift    = 1'b0;
		clear    = 1'b0;
		if (accept) begin
			if (term) begin
				clear   = 1'b1;
				phase_d = PH_SEARCH;
				esc_d   = 1'b0;
				cnt_d   = '0;
				unique case (ph_eff)
					PH_SEARCH: begin cmd_push = 1'b1; cmd.code = ST_NO_KEY; end
					PH_COLON:  begin cmd_push = 1'b1; cmd.code = ST_NO_COLON; end
					PH_QUOTE:  begin cmd_push = 1'b1; cmd.code = ST_NOT_STRING; end
					PH_VALUE:  begin cmd_push = 1'b1; cmd.code = ST_UNTERMINATED; end
					default: ;
				endcase
			end else begin
				unique case (ph_eff)
					PH_SEARCH: shift = 1'b1;
					PH_COLON: begin
						if (c == CH_COLON) phase_d = PH_QUOTE;
						else if (is_space(c)) phase_d = PH_COLON;
						else begin
							phase_d  = PH_DONE;
							cmd_push = 1'b1;
							cmd.code = ST_NO_COLON;
						end
					end
					PH_QUOTE: begin
						if (c == CH_QUOTE) begin
							phase_d = PH_VALUE;
							cnt_d   = '0;
							esc_d   = 1'b0;
						end else if (!is_space(c)) begin
							phase_d  = PH_DONE;
							cmd_push = 1'b1;
							cmd.code = ST_NOT_STRING;
						end
					end
					PH_VALUE: begin
						if (!esc_q && c == CH_QUOTE) begin
							phase_d  = PH_DONE;
							cmd_push = 1'b1;
							cmd.op   = CMD_EMIT;
							cmd.cnt  = CNT_W'(emit_cnt);
						end else begin
							esc_d = !esc_q && (c == CH_BACKSLASH);
							if (cnt_q < CW'(VALUE_MAX)) begin
								cmd_push = 1'b1;
								cmd.op   = CMD_STORE;
								cmd.data = c;
								cmd.cnt  = CNT_W'(cnt_q);
								cnt_d    = CW'(cnt_q + 1'b1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			esc_q   <= 1'b0;
			cnt_q   <= '0;
			chk_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			cnt_q   <= cnt_d;
			if (clear || cfg_we) chk_q <= 1'b0;
			else if (shift) chk_q <= 1'b1;
		end
	end

	// sliding window, newest character at the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PATTERN_MAX; p++) window_q[p] <= '0;
		end else if (clear) begin
			for (int p = 0; p < PATTERN_MAX; p++) window_q[p] <= '0;
		end else if (shift) begin
			for (int p = 0; p < PATTERN_MAX - 1; p++) window_q[p] <= window_q[p+1];
			window_q[PATTERN_MAX-1] <= c;
		end
	end

endmodule

`default_nettype wire

// ----- design/jsfe_queue.sv -----
// ----------------------------------------------------------------------------
// jsfe_queue
// Short command queue that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfe_queue import jsfe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (do_pop)  rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= (QPTR_W + 1)'(count_q + 1'b1);
				2'b01:   count_q <= (QPTR_W + 1)'(count_q - 1'b1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/jsfe_back.sv -----
// ----------------------------------------------------------------------------
// jsfe_back
// Executes parser commands: writes value bytes into the value store, replays
// them on a closing quote, and sends status items through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfe_back import jsfe_pkg::*; #(
	parameter int VALUE_MAX = 63
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cmd_t      cmd_head,
	input  wire logic cmd_empty,
	output logic      cmd_pop,
	jsfe_out_if.source result_out
);

	localparam int CW = $clog2(VALUE_MAX + 1);
	localparam int AW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EMIT,
		B_STAT
	} bstate_t;

	bstate_t       state_q;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] lim_q;
	logic [2:0]    code_q;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_q;
	logic [7:0]    value_store [VALUE_MAX];
	logic          slot_free;
	logic          out_load;

	logic          out_valid_q;
	logic [7:0]    value_byte_q;
	logic [2:0]    status_q;
	logic          last_q;

	assign result_out.valid      = out_valid_q;
	assign result_out.value_byte = value_byte_q;
	assign result_out.status     = status_q;
	assign result_out.last       = last_q;

	assign slot_free = !out_valid_q || result_out.ready;
	assign cmd_pop   = (state_q == B_IDLE) && !cmd_empty;
	assign out_load  = slot_free && (state_q == B_EMIT || state_q == B_STAT);

	// next replay index; the registered read runs one index ahead of the output
	always_comb begin
		unique case (state_q)
			B_IDLE:  idx_d = '0;
			B_EMIT:  idx_d = slot_free ? CW'(idx_q + 1'b1) : idx_q;
			default: idx_d = idx_q;
		endcase
		rd_addr = (idx_d < CW'(VALUE_MAX)) ? AW'(idx_d) : '0;
	end

	// value store
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_head.op == CMD_STORE) value_store[AW'(cmd_head.cnt)] <= cmd_head.data;
		rd_data_q <= value_store[rd_addr];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			idx_q        <= '0;
			lim_q        <= '0;
			code_q       <= ST_FOUND;
			out_valid_q  <= 1'b0;
			value_byte_q <= '0;
			status_q     <= ST_FOUND;
			last_q       <= 1'b0;
		end else begin
			if (result_out.ready && !out_load) out_valid_q <= 1'b0;
			idx_q <= idx_d;
			unique case (state_q)
				B_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd_head.op)
							CMD_EMIT: begin
								lim_q   <= CW'(cmd_head.cnt);
								code_q  <= ST_FOUND;
								state_q <= (cmd_head.cnt == '0) ? B_STAT : B_EMIT;
							end
							CMD_STATUS: begin
								code_q  <= cmd_head.code;
								state_q <= B_STAT;
							end
							default: ;
						endcase
					end
				end
				B_EMIT: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						value_byte_q <= rd_data_q;
						status_q     <= ST_FOUND;
						last_q       <= 1'b0;
						if (CW'(idx_q + 1'b1) == lim_q) state_q <= B_STAT;
					end
				end
				B_STAT: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						value_byte_q <= CH_NUL;
						status_q     <= code_q;
						last_q       <= 1'b1;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/json_string_field_extractor_top.sv -----
// ----------------------------------------------------------------------------
// json_string_field_extractor_top
// Streaming extractor of one quoted string field from JSON text.
// ----------------------------------------------------------------------------
// Text enters one character per transfer on text_in; a zero character or
// end_of_text closes the text and restarts the block. The front end takes a
// character every cycle while its four-entry command queue has room: it
// matches the quoted key in a sliding window, checks for the colon and the
// opening quote, and sends each value byte to the back end, which writes it
// into the value store at one byte per cycle while idle. On the closing
// quote the back end replays up to the destination size minus one stored
// bytes, one per cycle while the output register is free, followed by a
// status item with last set. Sustained input rate is one character per
// cycle, limited by the single write port of the value store and by the
// output register during a replay. No clearing pass is needed after reset.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_field_extractor_top import jsfe_pkg::*; #(
	parameter int PATTERN_MAX = 31,
	parameter int VALUE_MAX   = 63
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	jsfe_in_if.sink                    text_in,
	jsfe_out_if.source                 result_out
);

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;

	// parser front end
	jsfe_front #(
		.PATTERN_MAX(PATTERN_MAX),
		.VALUE_MAX  (VALUE_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.text_in  (text_in),
		.cmd_push (cmd_push),
		.cmd      (push_cmd),
		.cmd_full (cmd_full)
	);

	// command queue
	jsfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.push_cmd(push_cmd),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.head    (head_cmd),
		.empty   (cmd_empty)
	);

	// value store and result sequencer
	jsfe_back #(
		.VALUE_MAX(VALUE_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_head  (head_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result_out(result_out)
	);

endmodule

`default_nettype wire
